[hw/rtl/awbg_pkg.sv]
// Shared types and constants for the AWB gain calibration block.
// No dependencies; imported by every module of the block except awbg_div_pipe.
package awbg_pkg;

    localparam int RATIO_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // First-level gains are kept 32 bits wide so the divide-by-zero code fits
    localparam int GAIN_W = 32;
    localparam logic [GAIN_W-1:0] DIV_ZERO_GAIN = 32'hFFFF_FFFF;
    localparam int UNITY_SHIFT = 10;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 32'h0000_0400;

    localparam int OUT_W = 16;
    localparam logic [OUT_W-1:0] GAIN_MAX = 16'hFFFF;

    localparam int TYP_RG_RESET = 911;
    localparam int TYP_BG_RESET = 744;
    localparam logic [1:0] SHIFT_RESET = 2'd2;

    localparam logic [1:0] CFG_TYP_RG = 2'd0;
    localparam logic [1:0] CFG_TYP_BG = 2'd1;
    localparam logic [1:0] CFG_SHIFT  = 2'd2;

    // Which channel is pinned at unity
    typedef enum logic [1:0] {
        CASE_G_UNITY,
        CASE_R_UNITY,
        CASE_B_UNITY,
        CASE_PICK
    } case_t;

    typedef struct packed {
        logic       zero;
        case_t      code;
        logic       den_r_zero;
        logic       den_b_zero;
        logic [1:0] shift;
    } ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] r;
        logic [GAIN_W-1:0] g;
        logic [GAIN_W-1:0] b;
        logic              need_div;
        logic              to_red;
        logic              zero;
        logic [1:0]        shift;
    } gains_t;

endpackage

[hw/rtl/awb_gain_from_otp_ratios.sv]
// Top level: AWB gains from measured R/G and B/G ratios against typical ratios.
// An input passes the front registers, the queue, the parallel R and B dividers,
// m1, m2, a second divider and the output register; one quotient bit per stage.
// Throughput one transaction per cycle unless in_stall is raised; a 4-entry queue takes items while output stalls.
// Reset empties the pipeline and loads typical ratios 911 and 744 and down shift 2.
// Depends on awbg_pkg, awbg_front, awbg_queue, awbg_back.
module awb_gain_from_otp_ratios
    import awbg_pkg::*;
#(
    parameter int RATIO_BITS = RATIO_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] measured_rg_ratio,
    input  logic [15:0] measured_bg_ratio,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red_gain,
    output logic [15:0] green_gain,
    output logic [15:0] blue_gain,
    output logic        applied,
    output logic        saturated
);

    localparam int N  = RATIO_BITS;
    localparam int QW = $bits(ctl_t) + 4 * N;

    logic          f_valid;
    ctl_t          f_ctl;
    logic [N-1:0]  f_a_r, f_d_r, f_a_b, f_d_b;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_data;
    ctl_t          q_ctl;
    logic [N-1:0]  q_a_r, q_d_r, q_a_b, q_d_b;

    awbg_front #(.RATIO_BITS(N)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .measured_rg_ratio(measured_rg_ratio),
        .measured_bg_ratio(measured_bg_ratio),
        .q_full           (q_full),
        .f_valid          (f_valid),
        .f_ctl            (f_ctl),
        .f_a_r            (f_a_r),
        .f_d_r            (f_d_r),
        .f_a_b            (f_a_b),
        .f_d_b            (f_d_b)
    );

    awbg_queue #(.DEPTH(QUEUE_DEPTH), .W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_data ({f_ctl, f_a_r, f_d_r, f_a_b, f_d_b}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign {q_ctl, q_a_r, q_d_r, q_a_b, q_d_b} = q_data;

    awbg_back #(.RATIO_BITS(N)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ctl     (q_ctl),
        .q_a_r     (q_a_r),
        .q_d_r     (q_d_r),
        .q_a_b     (q_a_b),
        .q_d_b     (q_d_b),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_gain  (red_gain),
        .green_gain(green_gain),
        .blue_gain (blue_gain),
        .applied   (applied),
        .saturated (saturated)
    );

endmodule

[hw/rtl/awbg_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; used by awbg_back.
module awbg_div_pipe #(
    parameter int NW = 26,
    parameter int DW = 16,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    logic          v_in     [NW];
    logic [NW-1:0] nq_in    [NW];
    logic [DW-1:0] rem_in   [NW];
    logic [DW-1:0] den_in   [NW];
    logic [SW-1:0] side_in_s[NW];
    logic [DW:0]   trial    [NW];
    logic          ge       [NW];
    logic [NW-1:0] nq_next  [NW];
    logic [DW-1:0] rem_next [NW];

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                v_in[k]      = in_valid;
                nq_in[k]     = num;
                rem_in[k]    = '0;
                den_in[k]    = den;
                side_in_s[k] = side_in;
            end
            else
            begin
                v_in[k]      = v_reg[k-1];
                nq_in[k]     = nq_reg[k-1];
                rem_in[k]    = rem_reg[k-1];
                den_in[k]    = den_reg[k-1];
                side_in_s[k] = side_reg[k-1];
            end
            // bring down the next numerator bit and try to subtract
            trial[k]    = {rem_in[k], nq_in[k][NW-1]};
            ge[k]       = (trial[k] >= {1'b0, den_in[k]});
            nq_next[k]  = {nq_in[k][NW-2:0], ge[k]};
            rem_next[k] = ge[k] ? DW'(trial[k] - {1'b0, den_in[k]}) : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                v_reg[k] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                nq_reg[k]   <= nq_next[k];
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in_s[k];
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

[hw/rtl/awbg_front.sv]
// Front end: configuration registers, input acceptance and case classification.
// Depends on awbg_pkg; feeds awbg_queue.
module awbg_front
    import awbg_pkg::*;
#(
    parameter int RATIO_BITS = RATIO_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           measured_rg_ratio,
    input  logic [15:0]           measured_bg_ratio,
    input  logic                  q_full,
    output logic                  f_valid,
    output ctl_t                  f_ctl,
    output logic [RATIO_BITS-1:0] f_a_r,
    output logic [RATIO_BITS-1:0] f_d_r,
    output logic [RATIO_BITS-1:0] f_a_b,
    output logic [RATIO_BITS-1:0] f_d_b
);

    logic [RATIO_BITS-1:0] typ_rg_reg;
    logic [RATIO_BITS-1:0] typ_bg_reg;
    logic [1:0]            shift_reg;

    logic                  f_valid_reg;
    logic                  f_valid_next;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [RATIO_BITS-1:0] a_r_reg, d_r_reg, a_b_reg, d_b_reg;
    logic [RATIO_BITS-1:0] a_r_next, d_r_next, a_b_next, d_b_next;

    logic                  accept;
    logic [RATIO_BITS-1:0] rg, bg;
    logic                  r_low, b_low;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            typ_rg_reg <= RATIO_BITS'(TYP_RG_RESET);
            typ_bg_reg <= RATIO_BITS'(TYP_BG_RESET);
            shift_reg  <= SHIFT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TYP_RG: typ_rg_reg <= cfg_data[RATIO_BITS-1:0];
                CFG_TYP_BG: typ_bg_reg <= cfg_data[RATIO_BITS-1:0];
                CFG_SHIFT:  shift_reg  <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    assign in_stall = f_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    assign rg    = measured_rg_ratio[RATIO_BITS-1:0];
    assign bg    = measured_bg_ratio[RATIO_BITS-1:0];
    assign r_low = (rg < typ_rg_reg);
    assign b_low = (bg < typ_bg_reg);

    always_comb
    begin
        ctl_next.zero  = (rg == '0) || (bg == '0);
        ctl_next.shift = shift_reg;
        if (b_low && r_low)
        begin
            ctl_next.code = CASE_G_UNITY;
        end
        else if (b_low)
        begin
            ctl_next.code = CASE_R_UNITY;
        end
        else if (r_low)
        begin
            ctl_next.code = CASE_B_UNITY;
        end
        else
        begin
            ctl_next.code = CASE_PICK;
        end
        // green pinned: divide typical by measured; otherwise measured by typical
        if (b_low && r_low)
        begin
            a_r_next = typ_rg_reg;
            d_r_next = rg;
            a_b_next = typ_bg_reg;
            d_b_next = bg;
        end
        else
        begin
            a_r_next = rg;
            d_r_next = typ_rg_reg;
            a_b_next = bg;
            d_b_next = typ_bg_reg;
        end
        ctl_next.den_r_zero = (d_r_next == '0);
        ctl_next.den_b_zero = (d_b_next == '0);
    end

    always_comb
    begin
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (f_valid_reg && !q_full)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            a_r_reg <= a_r_next;
            d_r_reg <= d_r_next;
            a_b_reg <= a_b_next;
            d_b_reg <= d_b_next;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_ctl   = ctl_reg;
    assign f_a_r   = a_r_reg;
    assign f_d_r   = d_r_reg;
    assign f_a_b   = a_b_reg;
    assign f_d_b   = d_b_reg;

endmodule

[hw/rtl/awbg_queue.sv]
// Short FIFO between the front end and the divider back end.
// Depends on awbg_pkg only for the default depth; generic width.
module awbg_queue
    import awbg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int W     = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          push;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign push      = push_valid && !full;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && pop_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && pop_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && pop_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/awbg_back.sv]
// Back end: unity-gain divisions, gain selection, second division,
// down shift, saturation and the output register. Depends on awbg_pkg, awbg_div_pipe.
module awbg_back
    import awbg_pkg::*;
#(
    parameter int RATIO_BITS = RATIO_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ctl_t                  q_ctl,
    input  logic [RATIO_BITS-1:0] q_a_r,
    input  logic [RATIO_BITS-1:0] q_d_r,
    input  logic [RATIO_BITS-1:0] q_a_b,
    input  logic [RATIO_BITS-1:0] q_d_b,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      red_gain,
    output logic [OUT_W-1:0]      green_gain,
    output logic [OUT_W-1:0]      blue_gain,
    output logic                  applied,
    output logic                  saturated
);

    localparam int N    = RATIO_BITS;
    localparam int QW1  = N + UNITY_SHIFT;
    localparam int PW   = GAIN_W + N;
    localparam int SWR  = $bits(ctl_t) + 2 * N;
    localparam int SWB  = 2 * N;
    localparam int SW2  = $bits(gains_t);

    logic adv;

    logic            r_v, b_v;
    logic [QW1-1:0]  quo_r, quo_b;
    logic [SWR-1:0]  side_r;
    logic [SWB-1:0]  side_b;
    ctl_t            ctl1;
    logic [N-1:0]    a_r1, d_r1, a_b1, d_b1;
    logic [GAIN_W-1:0] qr, qb;

    logic            m1_valid_reg;
    gains_t          m1_reg, m1_next;
    logic [N-1:0]    m1_t_reg, m1_t_next;
    logic [N-1:0]    m1_m_reg, m1_m_next;

    logic            m2_valid_reg;
    gains_t          m2_reg;
    logic [PW-1:0]   m2_prod_reg;
    logic [N-1:0]    m2_m_reg;

    logic            v2;
    logic [PW-1:0]   quo2;
    logic [SW2-1:0]  side2;
    gains_t          g2;
    logic [PW-1:0]   r_sh, g_sh, b_sh;
    logic            r_big, g_big, b_big;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     red_reg, red_next;
    logic [OUT_W-1:0]     green_reg, green_next;
    logic [OUT_W-1:0]     blue_reg, blue_next;
    logic                 applied_reg, applied_next;
    logic                 sat_reg, sat_next;

    // the whole back end holds while a finished result waits
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && q_valid;

    awbg_div_pipe #(.NW(QW1), .DW(N), .SW(SWR)) u_div_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (q_valid),
        .num      ({q_a_r, {UNITY_SHIFT{1'b0}}}),
        .den      (q_d_r),
        .side_in  ({q_ctl, q_a_r, q_d_r}),
        .out_valid(r_v),
        .quo      (quo_r),
        .side_out (side_r)
    );

    awbg_div_pipe #(.NW(QW1), .DW(N), .SW(SWB)) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (q_valid),
        .num      ({q_a_b, {UNITY_SHIFT{1'b0}}}),
        .den      (q_d_b),
        .side_in  ({q_a_b, q_d_b}),
        .out_valid(b_v),
        .quo      (quo_b),
        .side_out (side_b)
    );

    assign {ctl1, a_r1, d_r1} = side_r;
    assign {a_b1, d_b1}       = side_b;

    assign qr = ctl1.den_r_zero ? DIV_ZERO_GAIN : GAIN_W'(quo_r);
    assign qb = ctl1.den_b_zero ? DIV_ZERO_GAIN : GAIN_W'(quo_b);

    // pin one channel at unity and plan the dependent division
    always_comb
    begin
        m1_next.zero     = ctl1.zero;
        m1_next.shift    = ctl1.shift;
        m1_next.r        = UNITY_GAIN;
        m1_next.g        = UNITY_GAIN;
        m1_next.b        = UNITY_GAIN;
        m1_next.need_div = 1'b1;
        m1_next.to_red   = 1'b0;
        m1_t_next        = d_b1;
        m1_m_next        = a_b1;
        case (ctl1.code)
            CASE_G_UNITY:
            begin
                m1_next.r        = qr;
                m1_next.b        = qb;
                m1_next.need_div = 1'b0;
            end
            CASE_R_UNITY:
            begin
                m1_next.g = qr;
            end
            CASE_B_UNITY:
            begin
                m1_next.g      = qb;
                m1_next.to_red = 1'b1;
                m1_t_next      = d_r1;
                m1_m_next      = a_r1;
            end
            CASE_PICK:
            begin
                if (qb > qr)
                begin
                    m1_next.g      = qb;
                    m1_next.to_red = 1'b1;
                    m1_t_next      = d_r1;
                    m1_m_next      = a_r1;
                end
                else
                begin
                    m1_next.g = qr;
                end
            end
            default:
            begin
                m1_next.need_div = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg  <= r_v && b_v;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg      <= m1_next;
            m1_t_reg    <= m1_t_next;
            m1_m_reg    <= m1_m_next;
            m2_reg      <= m1_reg;
            m2_prod_reg <= PW'(m1_reg.g) * PW'(m1_t_reg);
            m2_m_reg    <= m1_m_reg;
        end
    end

    awbg_div_pipe #(.NW(PW), .DW(N), .SW(SW2)) u_div_2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (m2_valid_reg),
        .num      (m2_prod_reg),
        .den      (m2_m_reg),
        .side_in  (m2_reg),
        .out_valid(v2),
        .quo      (quo2),
        .side_out (side2)
    );

    assign g2 = gains_t'(side2);

    always_comb
    begin
        r_sh = ((g2.need_div && g2.to_red) ? quo2 : PW'(g2.r)) >> g2.shift;
        b_sh = ((g2.need_div && !g2.to_red) ? quo2 : PW'(g2.b)) >> g2.shift;
        g_sh = PW'(g2.g) >> g2.shift;
        r_big = |r_sh[PW-1:OUT_W];
        g_big = |g_sh[PW-1:OUT_W];
        b_big = |b_sh[PW-1:OUT_W];
        if (g2.zero)
        begin
            red_next     = '0;
            green_next   = '0;
            blue_next    = '0;
            applied_next = 1'b0;
            sat_next     = 1'b0;
        end
        else
        begin
            red_next     = r_big ? GAIN_MAX : r_sh[OUT_W-1:0];
            green_next   = g_big ? GAIN_MAX : g_sh[OUT_W-1:0];
            blue_next    = b_big ? GAIN_MAX : b_sh[OUT_W-1:0];
            applied_next = 1'b1;
            sat_next     = r_big || g_big || b_big;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            applied_reg <= applied_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_gain   = red_reg;
    assign green_gain = green_reg;
    assign blue_gain  = blue_reg;
    assign applied    = applied_reg;
    assign saturated  = sat_reg;

endmodule

[tb/testbench.sv]
// Self-checking bench for awb_gain_from_otp_ratios: directed and random ratio pairs,
// register settings across phases, random idling and a long output hold-off.
// Depends on awbg_pkg and the block's RTL.
module testbench
    import awbg_pkg::*;
();

    typedef struct {
        logic [15:0] rg;
        logic [15:0] bg;
    } ratio_pair_t;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        applied;
        logic        saturated;
    } gain_set_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_TYP_RG;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] measured_rg_ratio = '0;
    logic [15:0] measured_bg_ratio = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    logic        applied;
    logic        saturated;

    // Predictor's own copy of the registers
    logic [15:0] typ_rg_q = 16'(TYP_RG_RESET);
    logic [15:0] typ_bg_q = 16'(TYP_BG_RESET);
    logic [1:0]  shift_q = SHIFT_RESET;

    ratio_pair_t pending_pairs[$];
    gain_set_t   expected_gains[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_saturated = 0;
    int          n_unapplied = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    logic [1:0]  cfg_index_hold;
    logic [15:0] cfg_data_hold;

    awb_gain_from_otp_ratios i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .measured_rg_ratio (measured_rg_ratio),
        .measured_bg_ratio (measured_bg_ratio),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .red_gain          (red_gain),
        .green_gain        (green_gain),
        .blue_gain         (blue_gain),
        .applied           (applied),
        .saturated         (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] divide_or_max(logic [63:0] num, logic [63:0] den);
        if (den == 0)
            return 64'hFFFF_FFFF;
        return num / den;
    endfunction

    function automatic logic [15:0] shift_and_clip(logic [63:0] g, ref logic sat);
        logic [63:0] s;
        s = g >> shift_q;
        if (s > 64'hFFFF)
        begin
            sat = 1'b1;
            return 16'hFFFF;
        end
        return s[15:0];
    endfunction

    function automatic gain_set_t predict_gains(ratio_pair_t p);
        gain_set_t   e;
        logic [63:0] rg, bg, trg, tbg, r, g, b, gr, gb, unity;
        logic        sat;
        unity = 64'h400;
        rg = p.rg;
        bg = p.bg;
        trg = typ_rg_q;
        tbg = typ_bg_q;
        sat = 1'b0;
        e = '{default: '0};
        if (rg == 0 || bg == 0)
            return e;
        if (bg < tbg)
        begin
            if (rg < trg)
            begin
                g = unity;
                b = divide_or_max(unity * tbg, bg);
                r = divide_or_max(unity * trg, rg);
            end
            else
            begin
                r = unity;
                g = divide_or_max(unity * rg, trg);
                b = divide_or_max(g * tbg, bg);
            end
        end
        else if (rg < trg)
        begin
            b = unity;
            g = divide_or_max(unity * bg, tbg);
            r = divide_or_max(g * trg, rg);
        end
        else
        begin
            gb = divide_or_max(unity * bg, tbg);
            gr = divide_or_max(unity * rg, trg);
            // tie pins red
            if (gb > gr)
            begin
                b = unity;
                g = gb;
                r = divide_or_max(g * trg, rg);
            end
            else
            begin
                r = unity;
                g = gr;
                b = divide_or_max(g * tbg, bg);
            end
        end
        e.red = shift_and_clip(r, sat);
        e.green = shift_and_clip(g, sat);
        e.blue = shift_and_clip(b, sat);
        e.applied = 1'b1;
        e.saturated = sat;
        return e;
    endfunction

    // Driver: predict at acceptance, then advance to the next pair
    always @(posedge clk)
    begin
        ratio_pair_t p;
        if (in_valid && !in_stall)
        begin
            p.rg = measured_rg_ratio;
            p.bg = measured_bg_ratio;
            expected_gains.push_back(predict_gains(p));
            void'(pending_pairs.pop_front());
        end
        if (!(in_valid && in_stall))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if ((in_valid && !in_stall ? pending_pairs.size() > 0
                                             : pending_pairs.size() > 0))
            begin
                p = pending_pairs[0];
                in_valid <= 1'b1;
                measured_rg_ratio <= p.rg;
                measured_bg_ratio <= p.bg;
                if (!quiet && $urandom_range(0, 9) == 0)
                    in_gap <= $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here once requested
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor: compare against the oldest expectation, then decide the stall
    always @(posedge clk)
    begin
        gain_set_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_gains.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = expected_gains.pop_front();
                n_results++;
                if (e.saturated)
                    n_saturated++;
                if (!e.applied)
                    n_unapplied++;
                if (red_gain !== e.red)
                begin
                    $error("red_gain exp %0d got %0d", e.red, red_gain);
                    errors++;
                end
                if (green_gain !== e.green)
                begin
                    $error("green_gain exp %0d got %0d", e.green, green_gain);
                    errors++;
                end
                if (blue_gain !== e.blue)
                begin
                    $error("blue_gain exp %0d got %0d", e.blue, blue_gain);
                    errors++;
                end
                if (applied !== e.applied)
                begin
                    $error("applied exp %0d got %0d", e.applied, applied);
                    errors++;
                end
                if (saturated !== e.saturated)
                begin
                    $error("saturated exp %0d got %0d", e.saturated, saturated);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 9) == 0)
                out_gap <= $urandom_range(1, 13);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_index_hold = idx;
        cfg_data_hold = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (cfg_index_hold)
            CFG_TYP_RG: typ_rg_q = cfg_data_hold;
            CFG_TYP_BG: typ_bg_q = cfg_data_hold;
            CFG_SHIFT:  shift_q = cfg_data_hold[1:0];
            default: ;
        endcase
    endtask

    task automatic queue_pair(logic [15:0] rg, logic [15:0] bg);
        ratio_pair_t p;
        p.rg = rg;
        p.bg = bg;
        pending_pairs.push_back(p);
    endtask

    task automatic drain_block();
        while (pending_pairs.size() > 0 || in_valid || expected_gains.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Ratios near the typical values reach every branch; the rest spread wide
    function automatic logic [15:0] pick_ratio(logic [15:0] typ);
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(1, 4));
            2: return typ;
            3: return 16'($urandom_range(65000, 65535));
            default: return 16'(int'(typ) + int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    initial
    begin
        logic [15:0] settings[6][3];
        settings = '{
            '{16'd911, 16'd744, 16'd2},
            '{16'd1, 16'd1, 16'd0},
            '{16'hFFFF, 16'hFFFF, 16'd3},
            '{16'd0, 16'd500, 16'd1},
            '{16'd1200, 16'd0, 16'd0},
            '{16'd37, 16'd40000, 16'd3}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: zeros, extremes, each branch and the tie
        queue_pair(16'd0, 16'd500);
        queue_pair(16'd500, 16'd0);
        queue_pair(16'd0, 16'd0);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'd1, 16'd1);
        queue_pair(16'd1, 16'hFFFF);
        queue_pair(16'hFFFF, 16'd1);
        queue_pair(16'd911, 16'd744);
        queue_pair(16'd500, 16'd400);
        queue_pair(16'd1500, 16'd400);
        queue_pair(16'd500, 16'd1500);
        queue_pair(16'd1822, 16'd1488);
        queue_pair(16'd1000, 16'd2000);
        queue_pair(16'd2000, 16'd800);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'h5555, 16'hAAAA);
        drain_block();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                quiet = 1'b1;
            write_reg(CFG_TYP_RG, settings[ph][0]);
            write_reg(CFG_TYP_BG, settings[ph][1]);
            write_reg(CFG_SHIFT, settings[ph][2]);
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < 130; k++)
                queue_pair(pick_ratio(typ_rg_q), pick_ratio(typ_bg_q));
            drain_block();
        end

        $display("%0d results checked across six register settings: %0d saturated, %0d not applied",
                 n_results, n_saturated, n_unapplied);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
